>>> rtl/core/assert_macros.svh
// Assertion macros shared by the screen raster renderer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property at every rising clock edge outside reset.
`define ZSR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check an implication at every rising clock edge outside reset.
`define ZSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ZSR_ASSERT(label, clk, rst_n, prop, msg)
`define ZSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/core/zsr_pkg.sv
// Shared constants, types and colour function of the screen raster renderer.
`default_nettype none
package zsr_pkg;

  // Frame geometry
  localparam int SIDE_BORDER_CELLS  = 4;
  localparam int TOTAL_BORDER_LINES = 48;
  localparam int PICTURE_LINES_N    = 192;
  localparam int PICTURE_CELLS_N    = 32;

  // Field widths
  localparam int ADDR_W     = 13;
  localparam int DATA_W     = 8;
  localparam int LINE_W     = 8;
  localparam int CELL_W     = 6;
  localparam int PIX_W      = 16;
  localparam int PIX_N      = 8;
  localparam int BORDER_W   = 3;
  localparam int FMT_W      = 2;
  localparam int TOP_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int COL_W      = 5;

  // Screen memory layout: bitmap bytes then attribute bytes
  localparam int BITMAP_BYTES = 6144;
  localparam int ATTR_BYTES   = 768;
  localparam int ATTR_AW      = 10;
  localparam logic [ADDR_W-1:0] ATTR_BASE = ADDR_W'(BITMAP_BYTES);
  localparam logic [ADDR_W-1:0] MEM_BYTES = ADDR_W'(BITMAP_BYTES + ATTR_BYTES);
  localparam logic [ADDR_W-1:0] BITMAP_LAST = ADDR_W'(BITMAP_BYTES - 1);

  // Derived raster constants
  localparam logic [LINE_W-1:0] PICTURE_LINES = LINE_W'(PICTURE_LINES_N);
  localparam logic [LINE_W-1:0] TOTAL_BORDER  = LINE_W'(TOTAL_BORDER_LINES);
  localparam logic [LINE_W-1:0] LAST_LINE =
    LINE_W'(PICTURE_LINES_N + TOTAL_BORDER_LINES - 1);
  localparam logic [CELL_W-1:0] LAST_CELL =
    CELL_W'(PICTURE_CELLS_N + 2 * SIDE_BORDER_CELLS - 1);
  localparam logic [CELL_W-1:0] PIC_CELL_FIRST = CELL_W'(SIDE_BORDER_CELLS);
  localparam logic [CELL_W-1:0] PIC_CELL_END =
    CELL_W'(SIDE_BORDER_CELLS + PICTURE_CELLS_N);

  // Channel levels: 192 normal, 255 bright
  localparam int LEVEL_NORMAL = 192;
  localparam int LEVEL_BRIGHT = 255;
  localparam logic [4:0] L5_NORMAL = 5'(LEVEL_NORMAL >> 3);
  localparam logic [4:0] L5_BRIGHT = 5'(LEVEL_BRIGHT >> 3);
  localparam logic [5:0] L6_NORMAL = 6'(LEVEL_NORMAL >> 2);
  localparam logic [5:0] L6_BRIGHT = 6'(LEVEL_BRIGHT >> 2);

  // Register defaults
  localparam logic [TOP_W-1:0] TOP_BORDER_RESET = TOP_W'(24);

  // Colour format codes
  localparam logic [FMT_W-1:0] FMT_NONE   = 2'd0;
  localparam logic [FMT_W-1:0] FMT_RGB555 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_RGB565 = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COLOUR_FORMAT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_BORDER    = 1'b1;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_e;

  // Per-cell control info carried from the raster stage to the pixel stage
  typedef struct packed {
    logic                in_picture;
    logic [BORDER_W-1:0] border_colour;
    logic                flash_phase;
    logic [LINE_W-1:0]   line;
    logic [CELL_W-1:0]   column;
    logic                frame_end;
  } cell_info_t;

  typedef logic [PIX_N-1:0][PIX_W-1:0] pix_row_t;

  // Colour of index idx (bit 0 blue, bit 1 red, bit 2 green) in format fmt
  function automatic logic [PIX_W-1:0] colour_of(input logic [BORDER_W-1:0] idx,
                                                 input logic bright,
                                                 input logic [FMT_W-1:0] fmt);
    logic [4:0]       l5;
    logic [5:0]       l6;
    logic [4:0]       r5, g5, b5;
    logic [5:0]       g6;
    logic [PIX_W-1:0] c;
    l5 = bright ? L5_BRIGHT : L5_NORMAL;
    l6 = bright ? L6_BRIGHT : L6_NORMAL;
    r5 = idx[1] ? l5 : 5'd0;
    g5 = idx[2] ? l5 : 5'd0;
    b5 = idx[0] ? l5 : 5'd0;
    g6 = idx[2] ? l6 : 6'd0;
    unique case (fmt)
      FMT_RGB555: c = {1'b0, r5, g5, b5};
      FMT_RGB565: c = {r5, g6, b5};
      default:    c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/zsr_in_if.sv
// Command channel: screen memory writes and render requests.
`default_nettype none
interface zsr_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic [zsr_pkg::ADDR_W-1:0]     mem_address;
  logic [zsr_pkg::DATA_W-1:0]     mem_data;
  logic [zsr_pkg::BORDER_W-1:0]   border_colour;
  logic                           flash_phase;

  modport source (output valid, command, mem_address, mem_data, border_colour,
                  flash_phase, input ready);
  modport sink   (input valid, command, mem_address, mem_data, border_colour,
                  flash_phase, output ready);
endinterface
`default_nettype wire

>>> rtl/core/zsr_out_if.sv
// Cell channel: eight pixels of one cell with its raster position.
`default_nettype none
interface zsr_out_if;
  logic                         valid;
  logic                         ready;
  logic [zsr_pkg::PIX_W-1:0]    pixel_0;
  logic [zsr_pkg::PIX_W-1:0]    pixel_1;
  logic [zsr_pkg::PIX_W-1:0]    pixel_2;
  logic [zsr_pkg::PIX_W-1:0]    pixel_3;
  logic [zsr_pkg::PIX_W-1:0]    pixel_4;
  logic [zsr_pkg::PIX_W-1:0]    pixel_5;
  logic [zsr_pkg::PIX_W-1:0]    pixel_6;
  logic [zsr_pkg::PIX_W-1:0]    pixel_7;
  logic [zsr_pkg::LINE_W-1:0]   line_number;
  logic [zsr_pkg::CELL_W-1:0]   cell_column;
  logic                         frame_end;

  modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                  pixel_6, pixel_7, line_number, cell_column, frame_end,
                  input ready);
  modport sink   (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                  pixel_6, pixel_7, line_number, cell_column, frame_end,
                  output ready);
endinterface
`default_nettype wire

>>> rtl/core/zsr_screen_mem.sv
// Bitmap and attribute memories with the post-reset clearing pass.
`default_nettype none
module zsr_screen_mem (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           wr_en_i,
  input  wire logic [zsr_pkg::ADDR_W-1:0]     wr_addr_i,
  input  wire logic [zsr_pkg::DATA_W-1:0]     wr_data_i,
  input  wire logic                           rd_en_i,
  input  wire logic [zsr_pkg::ADDR_W-1:0]     bm_raddr_i,
  input  wire logic [zsr_pkg::ATTR_AW-1:0]    at_raddr_i,
  output logic      [zsr_pkg::DATA_W-1:0]     bm_rdata_o,
  output logic      [zsr_pkg::DATA_W-1:0]     at_rdata_o,
  output logic                                clr_done_o
);

  logic [zsr_pkg::DATA_W-1:0] bm_mem [zsr_pkg::BITMAP_BYTES];
  logic [zsr_pkg::DATA_W-1:0] at_mem [zsr_pkg::ATTR_BYTES];

  logic                       clr_busy_q, clr_busy_d;
  logic [zsr_pkg::ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [zsr_pkg::DATA_W-1:0] bm_rdata_q, at_rdata_q;

  // Sweep every bitmap row once; attribute rows ride along for the first part
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == zsr_pkg::BITMAP_LAST) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  // Write port: clearing pass, else a command write; addresses past the end drop
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      bm_mem[clr_cnt_q] <= '0;
      if (clr_cnt_q < zsr_pkg::ADDR_W'(zsr_pkg::ATTR_BYTES)) begin
        at_mem[clr_cnt_q[zsr_pkg::ATTR_AW-1:0]] <= '0;
      end
    end else if (wr_en_i) begin
      if (wr_addr_i < zsr_pkg::ATTR_BASE) begin
        bm_mem[wr_addr_i] <= wr_data_i;
      end else if (wr_addr_i < zsr_pkg::MEM_BYTES) begin
        // attribute range lies in one aligned 1K window, so the low bits index it
        at_mem[wr_addr_i[zsr_pkg::ATTR_AW-1:0]] <= wr_data_i;
      end
    end
  end

  // Registered read ports
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      bm_rdata_q <= bm_mem[bm_raddr_i];
      at_rdata_q <= at_mem[at_raddr_i];
    end
  end

  assign bm_rdata_o = bm_rdata_q;
  assign at_rdata_o = at_rdata_q;
  assign clr_done_o = !clr_busy_q;

endmodule
`default_nettype wire

>>> rtl/core/zsr_raster.sv
// Raster position counters, picture window decode and memory address generation.
`default_nettype none
module zsr_raster (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           advance_i,
  input  wire logic [zsr_pkg::TOP_W-1:0]      top_border_i,
  input  wire logic [zsr_pkg::BORDER_W-1:0]   border_colour_i,
  input  wire logic                           flash_phase_i,
  output zsr_pkg::cell_info_t                 info_o,
  output logic      [zsr_pkg::ADDR_W-1:0]     bm_raddr_o,
  output logic      [zsr_pkg::ATTR_AW-1:0]    at_raddr_o
);

  logic [zsr_pkg::LINE_W-1:0] line_q, line_d;
  logic [zsr_pkg::CELL_W-1:0] cell_q, cell_d;
  logic [zsr_pkg::LINE_W-1:0] top;
  logic [zsr_pkg::LINE_W-1:0] y;
  logic [zsr_pkg::CELL_W-1:0] x_full;
  logic [zsr_pkg::COL_W-1:0]  x;
  logic                       last_line, last_cell;

  // Clamp the top border to the total border height
  always_comb begin
    top = zsr_pkg::LINE_W'(top_border_i);
    if (top > zsr_pkg::TOTAL_BORDER) begin
      top = zsr_pkg::TOTAL_BORDER;
    end
  end

  assign last_line = (line_q == zsr_pkg::LAST_LINE);
  assign last_cell = (cell_q == zsr_pkg::LAST_CELL);
  assign y         = line_q - top;
  assign x_full    = cell_q - zsr_pkg::PIC_CELL_FIRST;
  assign x         = x_full[zsr_pkg::COL_W-1:0];

  // Describe the current cell
  always_comb begin
    info_o.in_picture    = (line_q >= top) && (line_q < top + zsr_pkg::PICTURE_LINES) &&
                           (cell_q >= zsr_pkg::PIC_CELL_FIRST) &&
                           (cell_q < zsr_pkg::PIC_CELL_END);
    info_o.border_colour = border_colour_i;
    info_o.flash_phase   = flash_phase_i;
    info_o.line          = line_q;
    info_o.column        = cell_q;
    info_o.frame_end     = last_line && last_cell;
  end

  // Interleaved bitmap address: third, pixel row, character row, column
  assign bm_raddr_o = {y[7:6], y[2:0], y[5:3], x};
  assign at_raddr_o = {y[7:3], x};

  // Step to the next cell, wrapping at line and frame end
  always_comb begin
    line_d = line_q;
    cell_d = cell_q;
    if (advance_i) begin
      if (last_cell) begin
        cell_d = '0;
        line_d = last_line ? '0 : line_q + 1'b1;
      end else begin
        cell_d = cell_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
      cell_q <= '0;
    end else begin
      line_q <= line_d;
      cell_q <= cell_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/zsr_pixel.sv
// Cell colouring: flash inversion, ink and paper selection, border fill.
`default_nettype none
module zsr_pixel (
  input  wire zsr_pkg::cell_info_t              info_i,
  input  wire logic [zsr_pkg::DATA_W-1:0]       bitmap_i,
  input  wire logic [zsr_pkg::DATA_W-1:0]       attr_i,
  input  wire logic [zsr_pkg::FMT_W-1:0]        fmt_i,
  output zsr_pkg::pix_row_t                     pix_o
);

  logic [zsr_pkg::DATA_W-1:0] bits;
  logic [zsr_pkg::PIX_W-1:0]  ink, paper, border;

  assign ink    = zsr_pkg::colour_of(attr_i[2:0], attr_i[6], fmt_i);
  assign paper  = zsr_pkg::colour_of(attr_i[5:3], attr_i[6], fmt_i);
  assign border = zsr_pkg::colour_of(info_i.border_colour, 1'b0, fmt_i);
  // Invert flashing cells in the active phase
  assign bits   = (info_i.flash_phase && attr_i[7]) ? ~bitmap_i : bitmap_i;

  // Pixel 0 takes bitmap bit 7
  always_comb begin
    for (int k = 0; k < zsr_pkg::PIX_N; k++) begin
      if (!info_i.in_picture) begin
        pix_o[k] = border;
      end else begin
        pix_o[k] = bits[zsr_pkg::PIX_N-1-k] ? ink : paper;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/zx_screen_raster_renderer_core.sv
// Top level of the screen raster renderer: config, two-stage cell pipeline.
//
//  Channel  Dir  Carries
//  req_i    in   command, mem_address, mem_data, border_colour, flash_phase
//  res_o    out  pixel_0..pixel_7, line_number, cell_column, frame_end
//  cfg_*    in   colour_format (index 0), top_border_lines (index 1)
//
// One transaction per cycle while req_i.ready is high; the memory read register and
// the cell stage load at the accepting edge, and the result register takes the cell
// from them once it is free and presents it on res_o. Writes produce no result.
// After reset the screen memory is cleared, one bitmap row per cycle, with the attribute
// rows cleared beside the first bitmap rows; req_i.ready stays low until then.
// A stall on res_o backs up through the cell stage into req_i.ready.
`default_nettype none
`include "assert_macros.svh"
module zx_screen_raster_renderer_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  zsr_in_if.sink                                 req_i,
  zsr_out_if.source                              res_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [zsr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [zsr_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  logic [zsr_pkg::FMT_W-1:0] fmt_q;
  logic [zsr_pkg::TOP_W-1:0] top_q;

  logic                       clr_done;
  logic                       out_free, stage_adv;
  logic                       in_fire, render_fire, write_fire, rd_en;
  zsr_pkg::cell_info_t        info, info_q;
  logic                       stage_valid_q, stage_valid_d;
  logic [zsr_pkg::ADDR_W-1:0] bm_raddr;
  logic [zsr_pkg::ATTR_AW-1:0] at_raddr;
  logic [zsr_pkg::DATA_W-1:0] bm_rdata, at_rdata;
  zsr_pkg::pix_row_t          pix, pix_q;
  logic                       out_valid_q, out_valid_d;
  logic [zsr_pkg::LINE_W-1:0] line_q;
  logic [zsr_pkg::CELL_W-1:0] col_q;
  logic                       end_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= zsr_pkg::FMT_RGB565;
      top_q <= zsr_pkg::TOP_BORDER_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        zsr_pkg::CFG_COLOUR_FORMAT: fmt_q <= cfg_data_i[zsr_pkg::FMT_W-1:0];
        zsr_pkg::CFG_TOP_BORDER:    top_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: result register frees the cell stage, which frees the input
  assign out_free    = !out_valid_q || res_o.ready;
  assign stage_adv   = !stage_valid_q || out_free;
  assign req_i.ready = clr_done && stage_adv;
  assign in_fire     = req_i.valid && req_i.ready;
  assign render_fire = in_fire && (req_i.command == zsr_pkg::CMD_RENDER);
  assign write_fire  = in_fire && (req_i.command == zsr_pkg::CMD_WRITE);
  assign rd_en       = render_fire && info.in_picture;

  zsr_raster u_raster (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .advance_i       (render_fire),
    .top_border_i    (top_q),
    .border_colour_i (req_i.border_colour),
    .flash_phase_i   (req_i.flash_phase),
    .info_o          (info),
    .bm_raddr_o      (bm_raddr),
    .at_raddr_o      (at_raddr)
  );

  zsr_screen_mem u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (write_fire),
    .wr_addr_i  (req_i.mem_address),
    .wr_data_i  (req_i.mem_data),
    .rd_en_i    (rd_en),
    .bm_raddr_i (bm_raddr),
    .at_raddr_i (at_raddr),
    .bm_rdata_o (bm_rdata),
    .at_rdata_o (at_rdata),
    .clr_done_o (clr_done)
  );

  // Cell stage: hold the cell info beside the registered memory data
  assign stage_valid_d = stage_adv ? render_fire : stage_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_fire) begin
      info_q <= info;
    end
  end

  zsr_pixel u_pixel (
    .info_i   (info_q),
    .bitmap_i (bm_rdata),
    .attr_i   (at_rdata),
    .fmt_i    (fmt_q),
    .pix_o    (pix)
  );

  // Result register
  assign out_valid_d = out_free ? stage_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_valid_q && out_free) begin
      pix_q  <= pix;
      line_q <= info_q.line;
      col_q  <= info_q.column;
      end_q  <= info_q.frame_end;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.pixel_0     = pix_q[0];
  assign res_o.pixel_1     = pix_q[1];
  assign res_o.pixel_2     = pix_q[2];
  assign res_o.pixel_3     = pix_q[3];
  assign res_o.pixel_4     = pix_q[4];
  assign res_o.pixel_5     = pix_q[5];
  assign res_o.pixel_6     = pix_q[6];
  assign res_o.pixel_7     = pix_q[7];
  assign res_o.line_number = line_q;
  assign res_o.cell_column = col_q;
  assign res_o.frame_end   = end_q;

  // No transaction may enter while the screen memory is still being cleared
  `ZSR_ASSERT_IMPL(a_no_accept_clearing, clk_i, rst_ni, in_fire, clr_done, "accept during clear")
  // A blocked cell stage keeps its cell
  `ZSR_ASSERT(a_stage_hold, clk_i, rst_ni, (stage_valid_q && !out_free) |=> stage_valid_q, "cell dropped")
  // Picture reads stay inside the bitmap area
  `ZSR_ASSERT_IMPL(a_bitmap_range, clk_i, rst_ni, rd_en, bm_raddr < zsr_pkg::ATTR_BASE, "bitmap address out of range")
  // Frame end marks exactly the last cell of the frame
  `ZSR_ASSERT_IMPL(a_frame_end, clk_i, rst_ni, res_o.valid, res_o.frame_end == ((res_o.line_number == zsr_pkg::LAST_LINE) && (res_o.cell_column == zsr_pkg::LAST_CELL)), "frame end mark wrong")

endmodule
`default_nettype wire

>>> verif/zsr_raster_checker.sv
// Checker for the screen raster renderer: mirrors its state, predicts each cell, compares.
`timescale 1ns / 1ps
module zsr_raster_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  zsr_in_if                                  req_i,
  zsr_out_if                                 res_i,
  input  logic                               cfg_we_i,
  input  logic [zsr_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [zsr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int unsigned                        cells_pending_o,
  output int unsigned                        fail_count_o
);
  import zsr_pkg::*;

  localparam int FRAME_LINES = PICTURE_LINES_N + TOTAL_BORDER_LINES;
  localparam int LINE_CELLS  = PICTURE_CELLS_N + 2 * SIDE_BORDER_CELLS;
  localparam int SCREEN_SIZE = BITMAP_BYTES + ATTR_BYTES;

  typedef struct packed {
    logic [PIX_N-1:0][PIX_W-1:0] pixels;
    logic [LINE_W-1:0]           line;
    logic [CELL_W-1:0]           column;
    logic                        last;
  } cell_t;

  // Mirror of the block state and registers
  logic [DATA_W-1:0] screen [SCREEN_SIZE];
  int                ras_line;
  int                ras_col;
  logic [FMT_W-1:0]  fmt;
  logic [TOP_W-1:0]  top_lines;

  cell_t       cells_due [$];
  cell_t       want;
  cell_t       got;
  int unsigned mismatches;

  assign fail_count_o = mismatches;

  // Colour of a three-bit index in the current output format
  function automatic logic [PIX_W-1:0] rgb_of(input logic [2:0] idx, input logic bright);
    logic [4:0] lv5;
    logic [5:0] lv6;
    logic [4:0] r5, g5, b5;
    logic [5:0] g6;
    lv5 = bright ? 5'(LEVEL_BRIGHT >> 3) : 5'(LEVEL_NORMAL >> 3);
    lv6 = bright ? 6'(LEVEL_BRIGHT >> 2) : 6'(LEVEL_NORMAL >> 2);
    r5  = idx[1] ? lv5 : 5'd0;
    g5  = idx[2] ? lv5 : 5'd0;
    b5  = idx[0] ? lv5 : 5'd0;
    g6  = idx[2] ? lv6 : 6'd0;
    case (fmt)
      FMT_RGB555: return {1'b0, r5, g5, b5};
      FMT_RGB565: return {r5, g6, b5};
      default:    return '0;
    endcase
  endfunction

  // Work out the cell at the current raster position
  function automatic cell_t render_cell(input logic [BORDER_W-1:0] border,
                                        input logic flash);
    cell_t            c;
    int               top;
    int               y, x;
    int               baddr, aaddr;
    logic [7:0]       bits, attr;
    logic [PIX_W-1:0] ink, paper;
    top = (int'(top_lines) > TOTAL_BORDER_LINES) ? TOTAL_BORDER_LINES : int'(top_lines);
    if (ras_line >= top && ras_line < top + PICTURE_LINES_N &&
        ras_col >= SIDE_BORDER_CELLS && ras_col < SIDE_BORDER_CELLS + PICTURE_CELLS_N) begin
      y     = ras_line - top;
      x     = ras_col - SIDE_BORDER_CELLS;
      baddr = ((y >> 6) << 11) | ((y & 7) << 8) | (((y >> 3) & 7) << 5) | x;
      aaddr = BITMAP_BYTES + (y >> 3) * PICTURE_CELLS_N + x;
      bits  = screen[baddr];
      attr  = screen[aaddr];
      ink   = rgb_of(attr[2:0], attr[6]);
      paper = rgb_of(attr[5:3], attr[6]);
      // Invert flashing cells in the active phase
      if (flash && attr[7]) bits = ~bits;
      for (int k = 0; k < PIX_N; k++) c.pixels[k] = bits[7-k] ? ink : paper;
    end else begin
      for (int k = 0; k < PIX_N; k++) c.pixels[k] = rgb_of(border, 1'b0);
    end
    c.line   = LINE_W'(ras_line);
    c.column = CELL_W'(ras_col);
    c.last   = (ras_line == FRAME_LINES - 1) && (ras_col == LINE_CELLS - 1);
    return c;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: cell line %0d column %0d %s expected 0x%0h actual 0x%0h",
               $time, want.line, want.column, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (screen[i]) screen[i] = '0;
      ras_line  = 0;
      ras_col   = 0;
      fmt       = FMT_RGB565;
      top_lines = TOP_BORDER_RESET;
      cells_due.delete();
      mismatches = 0;
      cells_pending_o <= 0;
    end else begin
      // Compare a result transaction with the oldest predicted cell
      if (res_i.valid && res_i.ready) begin
        got.pixels[0] = res_i.pixel_0;
        got.pixels[1] = res_i.pixel_1;
        got.pixels[2] = res_i.pixel_2;
        got.pixels[3] = res_i.pixel_3;
        got.pixels[4] = res_i.pixel_4;
        got.pixels[5] = res_i.pixel_5;
        got.pixels[6] = res_i.pixel_6;
        got.pixels[7] = res_i.pixel_7;
        got.line      = res_i.line_number;
        got.column    = res_i.cell_column;
        got.last      = res_i.frame_end;
        if (cells_due.size() == 0) begin
          $display("%0t: unexpected cell, expected none, actual line %0d column %0d", $time,
                   got.line, got.column);
          mismatches++;
        end else begin
          want = cells_due.pop_front();
          for (int k = 0; k < PIX_N; k++)
            check_field($sformatf("pixel_%0d", k), want.pixels[k], got.pixels[k]);
          check_field("line_number", want.line, got.line);
          check_field("cell_column", want.column, got.column);
          check_field("frame_end", want.last, got.last);
        end
      end
      // Apply a command transaction
      if (req_i.valid && req_i.ready) begin
        if (req_i.command == CMD_RENDER) begin
          cells_due.push_back(render_cell(req_i.border_colour, req_i.flash_phase));
          // Advance the raster, wrapping at the end of the frame
          if (ras_col + 1 >= LINE_CELLS) begin
            ras_col  = 0;
            ras_line = (ras_line + 1 >= FRAME_LINES) ? 0 : ras_line + 1;
          end else begin
            ras_col = ras_col + 1;
          end
        end else if (req_i.mem_address < MEM_BYTES) begin
          screen[req_i.mem_address] = req_i.mem_data;
        end
      end
      // Track register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COLOUR_FORMAT: fmt = cfg_data_i[FMT_W-1:0];
          CFG_TOP_BORDER:    top_lines = cfg_data_i[TOP_W-1:0];
          default: ;
        endcase
      end
      cells_pending_o <= cells_due.size();
    end
  end

endmodule

>>> verif/zx_screen_raster_renderer_core_tb.sv
// Testbench top for the screen raster renderer: commands, registers, back-pressure, verdict.
`timescale 1ns / 1ps
module zx_screen_raster_renderer_core_tb;
  import zsr_pkg::*;

  localparam int WATCHDOG_LIMIT    = 20000;
  localparam int LONG_STALL_CYCLES = 400;
  localparam int SETTLE_CYCLES     = 4;
  localparam int SWEEP_RENDERS     = 240;
  localparam int LINE_CELLS        = PICTURE_CELLS_N + 2 * SIDE_BORDER_CELLS;
  localparam int FRAME_CELLS       = (PICTURE_LINES_N + TOTAL_BORDER_LINES) * LINE_CELLS;
  localparam int ADDR_TOP          = (1 << ADDR_W) - 1;
  localparam logic [FMT_W-1:0] FMT_UNUSED = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           cells_pending;
  int unsigned           fail_count;

  // Stimulus knobs and raster tracking
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      renders_sent = 0;
  logic [TOP_W-1:0] top_now = TOP_BORDER_RESET;
  logic             long_stall_req = 1'b0;
  logic             long_stall_done = 1'b0;
  int unsigned      quiet_cycles;

  zsr_in_if  req_if ();
  zsr_out_if res_if ();

  zx_screen_raster_renderer_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  zsr_raster_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .req_i           (req_if),
    .res_i           (res_if),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .cells_pending_o (cells_pending),
    .fail_count_o    (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req && !long_stall_done) begin
        res_if.ready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
        long_stall_done = 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run after too long without any transaction
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("zx_screen_raster_renderer_core_tb failed");
    $finish;
  end

  // Offer one command transaction and hold it until accepted
  task automatic send_txn(input cmd_e cmd, input logic [ADDR_W-1:0] addr,
                          input logic [DATA_W-1:0] data,
                          input logic [BORDER_W-1:0] border, input logic flash);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_if.command       <= cmd;
    req_if.mem_address   <= addr;
    req_if.mem_data      <= data;
    req_if.border_colour <= border;
    req_if.flash_phase   <= flash;
    req_if.valid         <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    if (cmd == CMD_RENDER) renders_sent++;
  endtask

  // Drop valid and wait until every predicted cell has come out
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_idx  <= idx;
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_TOP_BORDER) top_now = value[TOP_W-1:0];
  endtask

  // Top border choice: extremes, oversized, or one not past the current raster line
  function automatic logic [TOP_W-1:0] pick_top();
    int line;
    line = (renders_sent % FRAME_CELLS) / LINE_CELLS;
    if (line > TOTAL_BORDER_LINES) line = TOTAL_BORDER_LINES;
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return TOP_W'(TOTAL_BORDER_LINES);
      2:       return TOP_W'($urandom_range(TOTAL_BORDER_LINES + 1, (1 << TOP_W) - 1));
      default: return TOP_W'($urandom_range(0, line));
    endcase
  endfunction

  // Address of the bitmap or attribute byte of a cell about to be rendered, else a random screen address
  function automatic logic [ADDR_W-1:0] upcoming_addr();
    int pos, line, col, top, y, x;
    pos  = (renders_sent + $urandom_range(0, LINE_CELLS)) % FRAME_CELLS;
    line = pos / LINE_CELLS;
    col  = pos % LINE_CELLS;
    top  = (int'(top_now) > TOTAL_BORDER_LINES) ? TOTAL_BORDER_LINES : int'(top_now);
    y    = line - top;
    x    = col - SIDE_BORDER_CELLS;
    if (y >= 0 && y < PICTURE_LINES_N && x >= 0 && x < PICTURE_CELLS_N) begin
      if ($urandom_range(0, 1))
        return ADDR_W'(BITMAP_BYTES + (y >> 3) * PICTURE_CELLS_N + x);
      return ADDR_W'(((y >> 6) << 11) | ((y & 7) << 8) | (((y >> 3) & 7) << 5) | x);
    end
    return ADDR_W'($urandom_range(0, int'(MEM_BYTES) - 1));
  endfunction

  task automatic random_write();
    int r;
    logic [ADDR_W-1:0] addr;
    r = $urandom_range(99);
    if (r < 15)
      addr = ADDR_W'($urandom_range(int'(MEM_BYTES), ADDR_TOP));
    else if (r < 60)
      addr = upcoming_addr();
    else
      addr = ADDR_W'($urandom_range(0, int'(MEM_BYTES) - 1));
    send_txn(CMD_WRITE, addr, DATA_W'($urandom), BORDER_W'($urandom), 1'($urandom));
  endtask

  task automatic random_txn();
    if ($urandom_range(0, 1))
      send_txn(CMD_RENDER, ADDR_W'($urandom), DATA_W'($urandom), BORDER_W'($urandom),
               1'($urandom));
    else
      random_write();
  endtask

  task automatic run_phase(input int n, input int unsigned idle, input int unsigned stall,
                           input logic [CFG_DATA_W-1:0] fmt_value,
                           input logic [TOP_W-1:0] top_value);
    drain();
    write_reg(CFG_COLOUR_FORMAT, fmt_value);
    write_reg(CFG_TOP_BORDER, top_value);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) random_txn();
  endtask

  // Render mostly, with some writes, until the raster reaches a given count
  task automatic sweep_to(input int unsigned target);
    while (renders_sent < target) begin
      if ($urandom_range(0, 5) == 0)
        random_write();
      else
        send_txn(CMD_RENDER, ADDR_W'($urandom), DATA_W'($urandom), BORDER_W'($urandom),
                 1'($urandom));
    end
  endtask

  initial begin
    int unsigned sweep_end;
    // Hold all inputs at known values and pulse reset
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= CFG_COLOUR_FORMAT;
    cfg_data             <= '0;
    req_if.valid         <= 1'b0;
    req_if.command       <= CMD_WRITE;
    req_if.mem_address   <= '0;
    req_if.mem_data      <= '0;
    req_if.border_colour <= '0;
    req_if.flash_phase   <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: border cells at reset settings
    send_txn(CMD_RENDER, ADDR_W'(ADDR_TOP), 8'hFF, 3'd7, 1'b1);
    send_txn(CMD_RENDER, '0, 8'h00, 3'd0, 1'b0);
    drain();
    write_reg(CFG_TOP_BORDER, '0);
    // First picture cells: flashing bright attribute, plain attribute, memory extremes
    send_txn(CMD_WRITE, ADDR_W'(0), 8'hA5, 3'd0, 1'b0);
    send_txn(CMD_WRITE, ATTR_BASE, 8'hC1, 3'd0, 1'b0);
    send_txn(CMD_WRITE, ADDR_W'(1), 8'hFF, 3'd0, 1'b0);
    send_txn(CMD_WRITE, ATTR_BASE + ADDR_W'(1), 8'h38, 3'd0, 1'b0);
    send_txn(CMD_WRITE, ADDR_W'(ADDR_TOP), 8'h00, 3'd0, 1'b0);
    send_txn(CMD_WRITE, MEM_BYTES, 8'h55, 3'd0, 1'b0);
    send_txn(CMD_WRITE, MEM_BYTES - ADDR_W'(1), 8'h87, 3'd0, 1'b0);
    send_txn(CMD_WRITE, BITMAP_LAST, 8'hFF, 3'd0, 1'b0);
    send_txn(CMD_RENDER, '0, 8'h00, 3'd5, 1'b0);
    send_txn(CMD_RENDER, '0, 8'h00, 3'd2, 1'b1);
    send_txn(CMD_RENDER, '0, 8'h00, 3'd0, 1'b1);
    send_txn(CMD_RENDER, '0, 8'h00, 3'd0, 1'b1);
    send_txn(CMD_RENDER, '0, 8'h00, 3'd0, 1'b0);
    // RGB555 on a bright cell
    drain();
    write_reg(CFG_COLOUR_FORMAT, CFG_DATA_W'(FMT_RGB555));
    send_txn(CMD_WRITE, ADDR_W'(3), 8'h0F, 3'd0, 1'b0);
    send_txn(CMD_WRITE, ATTR_BASE + ADDR_W'(3), 8'h7A, 3'd0, 1'b0);
    send_txn(CMD_RENDER, '0, 8'h00, 3'd3, 1'b1);
    // Unused format code, with the upper data bits set, gives black
    drain();
    write_reg(CFG_COLOUR_FORMAT, {{(CFG_DATA_W - FMT_W){1'b1}}, FMT_UNUSED});
    send_txn(CMD_RENDER, '0, 8'h00, 3'd6, 1'b0);
    drain();
    write_reg(CFG_COLOUR_FORMAT, CFG_DATA_W'(FMT_NONE));
    send_txn(CMD_RENDER, '0, 8'h00, 3'd1, 1'b0);

    // Random phases across idling patterns and register settings
    run_phase(300, 0, 0, CFG_DATA_W'(FMT_RGB565), pick_top());
    run_phase(300, 64, 0, CFG_DATA_W'(FMT_RGB555), '0);
    run_phase(150, 0, 64, CFG_DATA_W'(FMT_NONE), TOP_W'((1 << TOP_W) - 1));
    run_phase(150, 29, 29, CFG_DATA_W'(FMT_UNUSED), TOP_W'(TOTAL_BORDER_LINES));

    // Long receiver hold-off while commands keep coming
    run_phase(0, 0, 0, CFG_DATA_W'(FMT_RGB565), pick_top());
    long_stall_req = 1'b1;
    while (!long_stall_done) random_txn();
    repeat (50) random_txn();

    run_phase(300, 29, 29, CFG_DATA_W'(FMT_RGB555), pick_top());
    run_phase(300, 0, 64, CFG_DATA_W'(FMT_RGB565), pick_top());

    // Sweep across several line ends, changing settings halfway
    sweep_end = renders_sent + SWEEP_RENDERS;
    run_phase(0, 0, 0, CFG_DATA_W'(FMT_RGB565), TOP_W'($urandom_range(0, 8)));
    sweep_to(renders_sent + (sweep_end - renders_sent) / 2);
    run_phase(0, 29, 29, CFG_DATA_W'(FMT_RGB555), TOP_W'($urandom_range(0, 16)));
    sweep_to(sweep_end);

    drain();
    if (fail_count == 0)
      $display("zx_screen_raster_renderer_core_tb passed");
    else
      $display("zx_screen_raster_renderer_core_tb failed");
    $finish;
  end

endmodule
